// ----- hw/rtl/mift_pkg.sv -----
// Shared types and codes for the message id filter table.
`default_nettype none

package mift_pkg;

  localparam int unsigned DefEntries = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned HandW   = 8;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INS_EXACT = 2'd0,
    OP_INS_RANGE = 2'd1,
    OP_CLASSIFY  = 2'd2,
    OP_UNDEF     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic             is_range;
    logic [KeyW-1:0]  low;
    logic [KeyW-1:0]  high;
    logic [HandW-1:0] handler;
  } rule_t;

endpackage

`default_nettype wire

// ----- hw/rtl/message_id_filter_table.sv -----
// Ordered first-match rule table: rule insert and message id classify.
//
// Input stream: tuser carries the operation (insert exact, insert range,
// classify); tdata carries key_low, key_high and handler_in. Each transfer
// gives exactly one result transfer: tuser is the status (ok, table full,
// no match), tdata the handler of the first matching rule or zero.
// Inserts write the rule into the table memory in the accept cycle, from
// slot rule_count. A classify walks the rules in order through one
// comparator, one table memory read issued per cycle with registered read
// data, and stops at the first hit or after the last rule; on an empty
// table it reports no match without a read. The block takes one item at a
// time; tready is high only while it waits for a new item.
// A result waits in the output register; if the receiver stalls and a
// further result is ready, the block holds it and accepts nothing until the
// output register frees. Reset empties the table (rule_count to zero) and
// drops any pending result; table contents need no clearing pass.
`default_nettype none

module message_id_filter_table #(
  parameter int unsigned ENTRIES = mift_pkg::DefEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] key_low, [15:8] key_high, [23:16] handler_in
  input  wire logic [23:0] s_axis_tdata_i,
  // [1:0] op
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] handler_out
  output logic [7:0]       m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]       m_axis_tuser_o
);
  import mift_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [CntW-1:0] CntFull = CntW'(ENTRIES);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  rule_t table_mem [ENTRIES];

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              chk_q, chk_d;
  logic              chk_last_q, chk_last_d;
  rule_t             rd_data_q;
  logic [KeyW-1:0]   key_q;
  status_e           res_status_q, res_status_d;
  logic [HandW-1:0]  res_handler_q, res_handler_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [HandW-1:0]  out_handler_q;

  logic              s_fire;
  logic              out_load;
  logic              issue;
  logic              hit;
  logic              mem_we;
  rule_t             wr_rule;
  op_e               in_op;
  logic [KeyW-1:0]   in_klo;
  logic [KeyW-1:0]   in_khi;
  logic [HandW-1:0]  in_hand;
  logic              full;

  assign in_op   = op_e'(s_axis_tuser_i);
  assign in_klo  = s_axis_tdata_i[7:0];
  assign in_khi  = s_axis_tdata_i[15:8];
  assign in_hand = s_axis_tdata_i[23:16];
  assign full    = (cnt_q == CntFull);

  // the shared comparator: range check, or equality for exact rules
  always_comb begin
    if (rd_data_q.is_range) begin
      hit = (key_q >= rd_data_q.low) && (key_q <= rd_data_q.high);
    end else begin
      hit = (key_q == rd_data_q.low);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (in_op == OP_CLASSIFY && cnt_q != '0) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (chk_q && (hit || chk_last_q)) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    s_fire          = s_axis_tvalid_i && s_axis_tready_o;
    issue           = (state_q == S_SCAN) && (rd_idx_q < cnt_q);
    out_load        = (state_q == S_RESP) && (!out_valid_q || m_axis_tready_i);
    mem_we          = 1'b0;
    cnt_d           = cnt_q;
    rd_idx_d        = rd_idx_q;
    chk_d           = issue;
    chk_last_d      = (rd_idx_q == cnt_q - CntOne);
    res_status_d    = res_status_q;
    res_handler_d   = res_handler_q;
    wr_rule.is_range = (in_op == OP_INS_RANGE);
    wr_rule.low      = in_klo;
    wr_rule.high     = (in_op == OP_INS_RANGE) ? in_khi : in_klo;
    wr_rule.handler  = in_hand;

    case (state_q)
      S_IDLE: begin
        rd_idx_d = '0;
        chk_d    = 1'b0;
        if (s_fire) begin
          res_handler_d = '0;
          case (in_op)
            OP_INS_EXACT, OP_INS_RANGE: begin
              if (full) begin
                res_status_d = ST_FULL;
              end else begin
                res_status_d = ST_OK;
                mem_we       = 1'b1;
                cnt_d        = cnt_q + CntOne;
              end
            end
            default: res_status_d = ST_NOMATCH;
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CntOne;
        end
        if (chk_q) begin
          if (hit) begin
            res_status_d  = ST_OK;
            res_handler_d = rd_data_q.handler;
          end else if (chk_last_q) begin
            res_status_d  = ST_NOMATCH;
          end
        end
      end
      default: ;
    endcase

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_last_q    <= chk_last_d;
    res_status_q  <= res_status_d;
    res_handler_q <= res_handler_d;
    if (s_fire) begin
      key_q <= in_klo;
    end
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_handler_q <= res_handler_q;
    end
  end

  // rule table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[cnt_q[IdxW-1:0]] <= wr_rule;
    end
    if (issue) begin
      rd_data_q <= table_mem[rd_idx_q[IdxW-1:0]];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = out_handler_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("rule count above table depth");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_op == OP_INS_EXACT || in_op == OP_INS_RANGE) && !full)
    |=> (cnt_q == $past(cnt_q) + CntOne) && (res_status_q == ST_OK))
    else $error("insert did not append a rule");

  a_empty_classify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_op == OP_CLASSIFY && cnt_q == '0)
    |=> (state_q == S_RESP) && (res_status_q == ST_NOMATCH))
    else $error("classify on empty table must report no match");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_valid_q && !m_axis_tready_i)
    |=> (state_q == S_RESP) && $stable(out_handler_q))
    else $error("pending result overwritten while output stalled");

endmodule

`default_nettype wire
